@@ rtl/matrix_stack_transform_engine_defines.svh @@
// Assertion macros used by the engine RTL.
`ifndef MATRIX_STACK_TRANSFORM_ENGINE_DEFINES_SVH
`define MATRIX_STACK_TRANSFORM_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MSTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MSTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MSTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/mste_pkg.sv @@
package mste_pkg;
  localparam int DATA_W          = 32;
  localparam int ACT_W           = 4;
  localparam int STAT_W          = 2;
  localparam int IDX_W           = 4;
  localparam int ELEMS           = 16;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ACT_W-1:0]         action_t;
  typedef logic [STAT_W-1:0]        status_t;
  typedef logic [IDX_W-1:0]         elem_idx_t;

  localparam action_t ACT_PUSH  = 4'd0;
  localparam action_t ACT_POP   = 4'd1;
  localparam action_t ACT_IDENT = 4'd2;
  localparam action_t ACT_WRITE = 4'd3;
  localparam action_t ACT_LOAD  = 4'd4;
  localparam action_t ACT_MUL   = 4'd5;
  localparam action_t ACT_SCALE = 4'd6;
  localparam action_t ACT_TRANS = 4'd7;
  localparam action_t ACT_XFORM = 4'd8;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_PUSH_FULL = 2'd1;
  localparam status_t ST_POP_LAST  = 2'd2;

  // Shared multiply-accumulate controls
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctl_t;

  // Identity element: diagonal words are 1.0
  function automatic data_t ident_elem(elem_idx_t w, int frac);
    data_t one_q;
    one_q = data_t'(1) <<< frac;
    return (w[1:0] == w[3:2]) ? one_q : '0;
  endfunction
endpackage

@@ rtl/mste_if.sv @@
interface mste_in_if;
  import mste_pkg::*;
  logic      valid;
  logic      ready;
  action_t   action;
  elem_idx_t element_index;
  data_t     value;
  data_t     coord_x;
  data_t     coord_y;
  data_t     coord_z;
  modport source (output valid, action, element_index, value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, action, element_index, value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface mste_out_if;
  import mste_pkg::*;
  logic    valid;
  logic    ready;
  data_t   out_x;
  data_t   out_y;
  data_t   out_z;
  status_t status;
  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink   (input valid, out_x, out_y, out_z, status, output ready);
endinterface

@@ rtl/matrix_stack_transform_engine.sv @@
// Channel   | Direction | Payload
// in_ch     | sink      | action, element_index, value, coord_x/y/z
// out_ch    | source    | out_x, out_y, out_z, status (one per input transfer)
//
// An item is taken only while idle, so items are processed one at a time.
// The work per item rests on one shared multiplier, which forms each
// computed output word, and on the single read port of the stack memory,
// which fetches a row word by word.
// Reset: stack count to one, operand matrix to zero, entry zero reads identity.
// A stalled result holds in the output register; the next item is still taken.
`include "matrix_stack_transform_engine_defines.svh"
module matrix_stack_transform_engine #(
  parameter int STACK_DEPTH = mste_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = mste_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mste_in_if.sink    in_ch,
  mste_out_if.source out_ch
);
  import mste_pkg::*;

  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int TW    = $clog2(STACK_DEPTH);
  localparam int WORDS = STACK_DEPTH * ELEMS;
  localparam int AW    = TW + IDX_W;
  localparam data_t FIX_ONE = data_t'(1) <<< FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COPY = 3'd1;  // push / identity / load sweep
  localparam logic [2:0] S_LOAD = 3'd2;  // fetch one row of the top
  localparam logic [2:0] S_MAC  = 3'd3;  // compute row outputs
  localparam logic [2:0] S_DONE = 3'd4;  // hand result to output register

  logic [2:0]    state_r;
  logic [CW-1:0] cnt_r;
  action_t       act_r;
  data_t         cx_r, cy_r, cz_r;
  data_t         op_r [ELEMS];
  data_t         rowbuf_r [4];
  data_t         res_r [3];
  status_t       status_r;
  logic [4:0]    e_r;
  logic [2:0]    k_r;
  logic [2:0]    j_r;
  logic [1:0]    row_r;
  logic [1:0]    col_r;
  logic          out_valid_r;
  data_t         out_x_r, out_y_r, out_z_r;
  status_t       out_status_r;

  logic [TW-1:0] top_idx;
  logic [TW-1:0] push_idx;
  logic          accept;
  logic          is_push;
  logic [4:0]    e_m1;
  logic [2:0]    k_m1;
  logic [4:0]    copy_last;
  logic [1:0]    col_first, col_last, row_last;
  logic [1:0]    j2;
  data_t         coord_sel;
  data_t         mac_a, mac_b, mac_result;
  mac_ctl_t      mac_ctl;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  data_t         wr_data, rd_data;

  assign top_idx  = TW'(cnt_r - 1'b1);
  assign push_idx = TW'(cnt_r);
  assign accept   = in_ch.valid && in_ch.ready;
  assign is_push  = (act_r == ACT_PUSH);
  assign e_m1     = e_r - 5'd1;
  assign k_m1     = k_r - 3'd1;
  // push sweeps one element further: its write lags the registered read
  assign copy_last = is_push ? 5'd16 : 5'd15;

  assign col_first = (act_r == ACT_TRANS || act_r == ACT_XFORM) ? 2'd3 : 2'd0;
  assign col_last  = (act_r == ACT_SCALE) ? 2'd2 : 2'd3;
  assign row_last  = (act_r == ACT_XFORM) ? 2'd2 : 2'd3;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_x  = out_x_r;
  assign out_ch.out_y  = out_y_r;
  assign out_ch.out_z  = out_z_r;
  assign out_ch.status = out_status_r;

  // MAC operands: term j of a row uses the fetched row word j
  assign j2    = j_r[1:0];
  assign mac_a = rowbuf_r[j2];
  always_comb begin
    case (j2)
      2'd0:    coord_sel = cx_r;
      2'd1:    coord_sel = cy_r;
      2'd2:    coord_sel = cz_r;
      default: coord_sel = FIX_ONE;  // w = 1 term passes column 3 through
    endcase
    case (act_r)
      ACT_MUL:   mac_b = op_r[{col_r, j2}];
      ACT_SCALE: mac_b = (j2 == col_r) ? coord_sel : '0;
      ACT_TRANS: mac_b = coord_sel;
      ACT_XFORM: mac_b = coord_sel;
      default:   mac_b = '0;
    endcase
  end

  assign mac_ctl.mul_en  = (state_r == S_MAC) && !j_r[2];
  assign mac_ctl.acc_en  = (state_r == S_MAC) && (j_r != 3'd0);
  assign mac_ctl.acc_clr = (j_r == 3'd1);

  // Memory port steering
  always_comb begin
    rd_addr = {top_idx, e_r[IDX_W-1:0]};
    wr_en   = 1'b0;
    wr_addr = {top_idx, e_r[IDX_W-1:0]};
    wr_data = mac_result;
    case (state_r)
      S_COPY: begin
        if (is_push) begin
          wr_en   = (e_r != 5'd0);
          wr_addr = {push_idx, e_m1[IDX_W-1:0]};
          wr_data = rd_data;
        end else begin
          wr_en   = 1'b1;
          wr_data = (act_r == ACT_IDENT) ? ident_elem(e_r[IDX_W-1:0], FRAC_BITS)
                                         : op_r[e_r[IDX_W-1:0]];
        end
      end
      S_LOAD: begin
        rd_addr = {top_idx, k_r[1:0], row_r};
      end
      S_MAC: begin
        wr_en   = (j_r == 3'd4) && (act_r != ACT_XFORM);
        wr_addr = {top_idx, col_r, row_r};
      end
      default: begin
      end
    endcase
  end

  mste_store #(.DEPTH(WORDS), .FRAC_BITS(FRAC_BITS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mste_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .a      (mac_a),
    .b      (mac_b),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < ELEMS; i++) begin
        op_r[i] <= '0;
      end
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r    <= in_ch.action;
            cx_r     <= in_ch.coord_x;
            cy_r     <= in_ch.coord_y;
            cz_r     <= in_ch.coord_z;
            res_r[0] <= '0;
            res_r[1] <= '0;
            res_r[2] <= '0;
            status_r <= (in_ch.action == ACT_PUSH && cnt_r >= CW'(STACK_DEPTH)) ?
                        ST_PUSH_FULL :
                        (in_ch.action == ACT_POP && cnt_r <= CW'(1)) ?
                        ST_POP_LAST : ST_OK;
            e_r      <= '0;
            k_r      <= '0;
            j_r      <= '0;
            row_r    <= '0;
            col_r    <= (in_ch.action == ACT_TRANS || in_ch.action == ACT_XFORM) ?
                        2'd3 : 2'd0;
            case (in_ch.action)
              ACT_PUSH: begin
                if (cnt_r >= CW'(STACK_DEPTH)) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_COPY;
                end
              end
              ACT_POP: begin
                if (cnt_r > CW'(1)) begin
                  cnt_r <= cnt_r - 1'b1;
                end
                state_r <= S_DONE;
              end
              ACT_IDENT, ACT_LOAD: state_r <= S_COPY;
              ACT_WRITE: begin
                op_r[in_ch.element_index] <= in_ch.value;
                state_r <= S_DONE;
              end
              ACT_MUL, ACT_SCALE, ACT_TRANS, ACT_XFORM: state_r <= S_LOAD;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_COPY: begin
          e_r <= e_r + 5'd1;
          if (e_r == copy_last) begin
            if (is_push) begin
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_LOAD: begin
          k_r <= k_r + 3'd1;
          if (k_r != 3'd0) begin
            rowbuf_r[k_m1[1:0]] <= rd_data;
          end
          if (k_r == 3'd4) begin
            j_r     <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (j_r == 3'd4) begin
            j_r <= '0;
            if (act_r == ACT_XFORM) begin
              res_r[row_r] <= mac_result;
            end
            if (col_r == col_last) begin
              col_r <= col_first;
              if (row_r == row_last) begin
                state_r <= S_DONE;
              end else begin
                row_r   <= row_r + 2'd1;
                k_r     <= '0;
                state_r <= S_LOAD;
              end
            end else begin
              col_r <= col_r + 2'd1;
            end
          end else begin
            j_r <= j_r + 3'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_x_r      <= res_r[0];
            out_y_r      <= res_r[1];
            out_z_r      <= res_r[2];
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Stack count always within its live range while idle
  `MSTE_ASSERT_IMP(a_cnt_range, clk, rst_n, state_r == S_IDLE, cnt_r != '0 && cnt_r <= CW'(STACK_DEPTH), "stack count out of range")
  // Full-stack error only reported with a full stack
  `MSTE_ASSERT_IMP(a_full_err, clk, rst_n, state_r == S_DONE && status_r == ST_PUSH_FULL, cnt_r == CW'(STACK_DEPTH), "push error without full stack")
  // No memory write while a row is being fetched
  `MSTE_ASSERT_IMP(a_no_wr_load, clk, rst_n, state_r == S_LOAD, !wr_en, "write during row fetch")
  // An accepted item always leaves idle
  `MSTE_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, state_r != S_IDLE, "accepted item not started")
endmodule

@@ rtl/mste_ram.sv @@
module mste_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

@@ rtl/mste_store.sv @@
module mste_store #(
  parameter int DEPTH     = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  mste_pkg::data_t          wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output mste_pkg::data_t          rd_data
);
  import mste_pkg::*;
  localparam int AW = $clog2(DEPTH);

  logic [ELEMS-1:0]  base_vld_r;
  logic              ident_sel_r;
  elem_idx_t         rd_word_r;
  logic [DATA_W-1:0] ram_q;
  logic              rd_base;
  logic              wr_base;

  // Entry zero reads as identity until each word is written
  assign rd_base = (rd_addr[AW-1:IDX_W] == '0);
  assign wr_base = (wr_addr[AW-1:IDX_W] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_vld_r <= '0;
    end else if (wr_en && wr_base) begin
      base_vld_r[wr_addr[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ident_sel_r <= rd_base && !base_vld_r[rd_addr[IDX_W-1:0]];
    rd_word_r   <= rd_addr[IDX_W-1:0];
  end

  mste_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign rd_data = ident_sel_r ? ident_elem(rd_word_r, FRAC_BITS) : data_t'(ram_q);
endmodule

@@ rtl/mste_mac.sv @@
module mste_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  mste_pkg::mac_ctl_t ctl,
  input  mste_pkg::data_t    a,
  input  mste_pkg::data_t    b,
  output mste_pkg::data_t    result
);
  import mste_pkg::*;
  localparam int PW    = 2 * DATA_W;
  localparam int ACC_W = DATA_W + 2;
  localparam data_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    shifted;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] sum;
  data_t                   term;

  // Floor shift then clamp the product to 32 bits
  assign shifted = prod_r >>> FRAC_BITS;
  always_comb begin
    if ((&shifted[PW-1:DATA_W-1]) || !(|shifted[PW-1:DATA_W-1])) begin
      term = shifted[DATA_W-1:0];
    end else begin
      term = shifted[PW-1] ? Q_MIN : Q_MAX;
    end
  end

  assign sum = (ctl.acc_clr ? ACC_W'(0) : acc_r) + {{2{term[DATA_W-1]}}, term};

  always_comb begin
    if ((&sum[ACC_W-1:DATA_W-1]) || !(|sum[ACC_W-1:DATA_W-1])) begin
      result = sum[DATA_W-1:0];
    end else begin
      result = sum[ACC_W-1] ? Q_MIN : Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= a * b;
    end
    if (ctl.acc_en) begin
      acc_r <= sum;
    end
  end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mste_pkg::*;

  localparam int DEPTH   = STACK_DEPTH_DEF;
  localparam int FRAC    = FRAC_BITS_DEF;
  localparam data_t ONE  = data_t'(1) <<< FRAC;
  localparam data_t QMAX = 32'sh7fff_ffff;
  localparam data_t QMIN = 32'sh8000_0000;
  localparam action_t ACT_SPARE = 4'd15;   // beyond the last defined action

  typedef struct {
    action_t   action;
    elem_idx_t idx;
    data_t     value;
    data_t     cx;
    data_t     cy;
    data_t     cz;
  } cmd_t;

  typedef struct {
    data_t   x;
    data_t   y;
    data_t   z;
    status_t status;
  } point_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mste_in_if  in_ch ();
  mste_out_if out_ch ();

  matrix_stack_transform_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the stack, depth and staging matrix
  data_t   shadow_stack [DEPTH][16];
  int      shadow_count;
  data_t   shadow_operand [16];

  cmd_t       cmd_queue [$];
  point_res_t expected_points [$];
  logic       in_fire = 1'b0;
  bit         failed = 1'b0;
  int unsigned cyc = 0;

  // Idle-free stretch somewhere in the middle of the run
  wire calm = (cyc >= 30000) && (cyc < 50000);

  function automatic data_t sat32(longint v);
    if (v > longint'(QMAX)) return QMAX;
    if (v < longint'(QMIN)) return QMIN;
    return data_t'(v);
  endfunction

  // Exact product, floor shift, saturate
  function automatic data_t qmul(data_t a, data_t b);
    longint pa, pb;
    pa = a;
    pb = b;
    return sat32((pa * pb) >>> FRAC);
  endfunction

  function automatic void reset_shadow();
    for (int k = 0; k < 16; k++) begin
      shadow_operand[k] = '0;
      for (int e = 0; e < DEPTH; e++) shadow_stack[e][k] = '0;
      shadow_stack[0][k] = (k % 5 == 0) ? ONE : '0;
    end
    shadow_count = 1;
  endfunction

  // Applies one action to the shadow state and returns the expected result
  function automatic point_res_t stack_engine_step(cmd_t c);
    point_res_t res;
    data_t      tmp [16];
    longint     s;
    int         t;
    res = '{x: '0, y: '0, z: '0, status: ST_OK};
    t = shadow_count - 1;
    case (c.action)
      ACT_PUSH: begin
        if (shadow_count >= DEPTH) res.status = ST_PUSH_FULL;
        else begin
          shadow_stack[t+1] = shadow_stack[t];
          shadow_count++;
        end
      end
      ACT_POP: begin
        if (shadow_count <= 1) res.status = ST_POP_LAST;
        else shadow_count--;
      end
      ACT_IDENT:
        for (int k = 0; k < 16; k++) shadow_stack[t][k] = (k % 5 == 0) ? ONE : '0;
      ACT_WRITE: shadow_operand[c.idx] = c.value;
      ACT_LOAD:  shadow_stack[t] = shadow_operand;
      ACT_MUL: begin
        for (int r = 0; r < 4; r++)
          for (int col = 0; col < 4; col++) begin
            s = 0;
            for (int k = 0; k < 4; k++)
              s += qmul(shadow_stack[t][4*k+r], shadow_operand[4*col+k]);
            tmp[4*col+r] = sat32(s);
          end
        shadow_stack[t] = tmp;
      end
      ACT_SCALE:
        for (int r = 0; r < 4; r++) begin
          shadow_stack[t][r]   = qmul(shadow_stack[t][r], c.cx);
          shadow_stack[t][4+r] = qmul(shadow_stack[t][4+r], c.cy);
          shadow_stack[t][8+r] = qmul(shadow_stack[t][8+r], c.cz);
        end
      ACT_TRANS, ACT_XFORM:
        for (int r = 0; r < 4; r++) begin
          s = longint'(qmul(shadow_stack[t][r], c.cx)) + qmul(shadow_stack[t][4+r], c.cy)
            + qmul(shadow_stack[t][8+r], c.cz) + shadow_stack[t][12+r];
          if (c.action == ACT_TRANS) shadow_stack[t][12+r] = sat32(s);
          else if (r == 0) res.x = sat32(s);
          else if (r == 1) res.y = sat32(s);
          else if (r == 2) res.z = sat32(s);
        end
      default: ;
    endcase
    return res;
  endfunction

  // Fixed-point value: mostly modest magnitudes, some extremes and raw words
  function automatic data_t rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2: return data_t'($urandom_range(0, 32'h3ffff)) - 32'sh2_0000;
      3, 4:    return ONE + data_t'($urandom_range(0, 32'h1ffff)) - 32'sh1_0000;
      5:       return data_t'($urandom);
      6: begin
        case ($urandom_range(0, 4))
          0: return QMAX;
          1: return QMIN;
          2: return '0;
          3: return -ONE;
          default: return ONE;
        endcase
      end
      default: return data_t'($urandom_range(0, 32'h7ff_ffff)) - 32'sh400_0000;
    endcase
  endfunction

  function automatic cmd_t make_cmd(action_t a, data_t x, data_t y, data_t z);
    cmd_t c;
    c.action = a;
    c.idx    = elem_idx_t'($urandom);
    c.value  = rand_q();
    c.cx     = x;
    c.cy     = y;
    c.cz     = z;
    return c;
  endfunction

  // Driver: a new item goes out once the current one has transferred
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (cmd_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
        cmd_t c;
        c = cmd_queue.pop_front();
        in_ch.action        <= c.action;
        in_ch.element_index <= c.idx;
        in_ch.value         <= c.value;
        in_ch.coord_x       <= c.cx;
        in_ch.coord_y       <= c.cy;
        in_ch.coord_z       <= c.cz;
        in_ch.valid         <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 23);
  end

  // Monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    cyc <= cyc + 1;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cmd_t c;
      c.action = in_ch.action;
      c.idx    = in_ch.element_index;
      c.value  = in_ch.value;
      c.cx     = in_ch.coord_x;
      c.cy     = in_ch.coord_y;
      c.cz     = in_ch.coord_z;
      expected_points.push_back(stack_engine_step(c));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h status=%0d", $time,
                 out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.status);
        failed = 1'b1;
      end else begin
        point_res_t e;
        e = expected_points.pop_front();
        if (out_ch.out_x !== e.x || out_ch.out_y !== e.y || out_ch.out_z !== e.z ||
            out_ch.status !== e.status) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                   $time, e.x, e.y, e.z, e.status,
                   out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.status);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int pick;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PUSH;
    in_ch.element_index = '0;
    in_ch.value = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
    reset_shadow();

    // Directed: pop of last entry, fill to full, push on full, extremes
    cmd_queue.push_back(make_cmd(ACT_POP, '0, '0, '0));
    for (int k = 0; k < DEPTH; k++) cmd_queue.push_back(make_cmd(ACT_PUSH, '0, '0, '0));
    cmd_queue.push_back(make_cmd(ACT_XFORM, QMAX, QMIN, QMAX));
    cmd_queue.push_back(make_cmd(ACT_WRITE, '0, '0, '0));
    cmd_queue[$].idx = 4'd0;  cmd_queue[$].value = QMAX;
    cmd_queue.push_back(make_cmd(ACT_WRITE, '0, '0, '0));
    cmd_queue[$].idx = 4'd15; cmd_queue[$].value = QMIN;
    cmd_queue.push_back(make_cmd(ACT_MUL, '0, '0, '0));
    cmd_queue.push_back(make_cmd(ACT_LOAD, '0, '0, '0));
    cmd_queue.push_back(make_cmd(ACT_SCALE, QMAX, QMIN, -ONE));
    cmd_queue.push_back(make_cmd(ACT_TRANS, QMIN, QMAX, QMIN));
    cmd_queue.push_back(make_cmd(ACT_XFORM, ONE, -ONE, QMIN));
    cmd_queue.push_back(make_cmd(ACT_IDENT, '0, '0, '0));
    cmd_queue.push_back(make_cmd(ACT_SPARE, QMAX, QMAX, QMAX));

    // Random: weighted towards building and using transforms
    for (int n = 0; n < 1950; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)      cmd_queue.push_back(make_cmd(ACT_PUSH, '0, '0, '0));
      else if (pick < 24) cmd_queue.push_back(make_cmd(ACT_POP, '0, '0, '0));
      else if (pick < 29) cmd_queue.push_back(make_cmd(ACT_IDENT, '0, '0, '0));
      else if (pick < 53) cmd_queue.push_back(make_cmd(ACT_WRITE, '0, '0, '0));
      else if (pick < 59) cmd_queue.push_back(make_cmd(ACT_LOAD, '0, '0, '0));
      else if (pick < 66) cmd_queue.push_back(make_cmd(ACT_MUL, '0, '0, '0));
      else if (pick < 73) cmd_queue.push_back(make_cmd(ACT_SCALE, rand_q(), rand_q(), rand_q()));
      else if (pick < 81) cmd_queue.push_back(make_cmd(ACT_TRANS, rand_q(), rand_q(), rand_q()));
      else if (pick < 96) cmd_queue.push_back(make_cmd(ACT_XFORM, rand_q(), rand_q(), rand_q()));
      else cmd_queue.push_back(make_cmd(action_t'($urandom_range(9, 15)),
                                        rand_q(), rand_q(), rand_q()));
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Drain: all stimulus sent, then all results back, then a quiet spell
    wait (cmd_queue.size() == 0 && !in_ch.valid);
    wait (expected_points.size() == 0);
    repeat (200) @(posedge clk);
    if (!failed) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mste_pkg.sv
rtl/mste_if.sv
rtl/mste_ram.sv
rtl/mste_store.sv
rtl/mste_mac.sv
rtl/matrix_stack_transform_engine.sv
tb/tb_top.sv
